// ===== rtl/pistore_pkg.sv =====
// shared constants and codes for the positional insert sequence store
`timescale 1ns / 1ps
`default_nettype none
package pistore_pkg;

  localparam int VALUE_W  = 32;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  localparam int CAPACITY_DEFAULT   = 1024;
  localparam int BLOCK_SIZE_DEFAULT = 32;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage
`default_nettype wire

// ===== rtl/positional_insert_sequence_store.sv =====
// top level: block-list sequence store with insert, append and query
`timescale 1ns / 1ps
`default_nettype none
// The sequence is kept as a list of blocks of up to 2*BLOCK_SIZE words each,
// in one of two element banks. A word is taken when start is high and busy is
// low; its result shows for one cycle with done high and cannot be held off.
// The result shows in the cycle right after the last busy cycle. An append
// writes straight into the last block. A query walks the block lengths to
// find the position (at most NUM_BLOCKS - 1 blocks walked) and then reads
// the element. An insert walks the same way and then moves each element of
// the found block from the position on up one slot, highest first (at most
// 2*BLOCK_SIZE - 1 elements). When the target block is full, the store first
// repacks every element into the other bank at BLOCK_SIZE per block, after
// which the word is handled again from the start; a repack happens at most
// once per BLOCK_SIZE words that add to the same block. No clearing pass
// is needed after reset.
module positional_insert_sequence_store #(
  parameter int CAPACITY   = pistore_pkg::CAPACITY_DEFAULT,
  parameter int BLOCK_SIZE = pistore_pkg::BLOCK_SIZE_DEFAULT
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic        [pistore_pkg::OP_W-1:0]    opcode,
  input  wire logic        [$clog2(CAPACITY+1)-1:0]   position,
  input  wire logic signed [pistore_pkg::VALUE_W-1:0] element_value,
  output logic                                        done,
  output logic signed      [pistore_pkg::VALUE_W-1:0] read_value,
  output logic             [pistore_pkg::STATUS_W-1:0] status,
  output logic             [$clog2(CAPACITY+1)-1:0]   element_count
);
  import pistore_pkg::*;

  localparam int COUNT_W    = $clog2(CAPACITY + 1);
  localparam int NUM_BLOCKS = (CAPACITY + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int SLOT_CAP   = 2 * BLOCK_SIZE;
  localparam int SLOT_W     = $clog2(SLOT_CAP);
  localparam int LEN_W      = $clog2(SLOT_CAP + 1);
  localparam int CMP_W      = (COUNT_W > LEN_W) ? COUNT_W : LEN_W;
  localparam int ADDR_W     = BLK_W + SLOT_W;
  localparam int DEPTH      = NUM_BLOCKS * (1 << SLOT_W);

  localparam logic [BLK_W-1:0]  LAST_BLK  = BLK_W'(NUM_BLOCKS - 1);
  localparam logic [LEN_W-1:0]  FULL_LEN  = LEN_W'(SLOT_CAP);
  localparam logic [SLOT_W-1:0] PACK_LAST = SLOT_W'(BLOCK_SIZE - 1);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECIDE  = 3'd1;
  localparam logic [2:0] S_LOCATE  = 3'd2;
  localparam logic [2:0] S_SHIFT   = 3'd3;
  localparam logic [2:0] S_QWAIT   = 3'd4;
  localparam logic [2:0] S_REBUILD = 3'd5;

  logic [2:0]          state;
  logic [OP_W-1:0]     op_q;
  logic [COUNT_W-1:0]  pos_q;
  logic [VALUE_W-1:0]  val_q;
  logic [COUNT_W-1:0]  count;
  logic                active;
  logic [LEN_W-1:0]    len [NUM_BLOCKS];
  logic [LEN_W-1:0]    len_fill [NUM_BLOCKS];

  // walk and shift
  logic [BLK_W-1:0]    walk_blk;
  logic [COUNT_W-1:0]  rem;
  logic [SLOT_W-1:0]   off;
  logic [SLOT_W-1:0]   rd_slot;
  logic                rd_active;
  logic                pipe_valid;
  logic [SLOT_W-1:0]   pipe_slot;

  // repack stream
  logic [BLK_W-1:0]    src_blk;
  logic [LEN_W-1:0]    src_slot;
  logic                src_done;
  logic [BLK_W-1:0]    dst_blk;
  logic [SLOT_W-1:0]   dst_slot;

  logic [LEN_W-1:0]    cur_len;
  logic [LEN_W-1:0]    last_len;
  logic [LEN_W-1:0]    src_len;
  logic                found;
  logic                pos_bad;
  logic                full;
  logic                rb_issue;

  logic                ren;
  logic [ADDR_W-1:0]   raddr;
  logic                wen;
  logic                wr_other;
  logic [ADDR_W-1:0]   waddr;
  logic [VALUE_W-1:0]  wdata;
  logic                wr_bank;
  logic [VALUE_W-1:0]  rdata0;
  logic [VALUE_W-1:0]  rdata1;
  logic [VALUE_W-1:0]  rdata_sel;

  assign busy      = (state != S_IDLE);
  assign cur_len   = len[walk_blk];
  assign last_len  = len[LAST_BLK];
  assign src_len   = len[src_blk];
  assign found     = CMP_W'(rem) < CMP_W'(cur_len);
  assign pos_bad   = (pos_q == '0) || (pos_q > count);
  assign full      = 32'(count) >= 32'(CAPACITY);
  assign rb_issue  = !src_done && (src_slot < src_len);
  assign rdata_sel = active ? rdata1 : rdata0;
  assign wr_bank   = active ^ wr_other;

  // block lengths after a repack: filled from the front, BLOCK_SIZE each
  for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_fill
    assign len_fill[k] =
      (32'(count) >= 32'((k + 1) * BLOCK_SIZE)) ? LEN_W'(BLOCK_SIZE) :
      (32'(count) > 32'(k * BLOCK_SIZE)) ?
        LEN_W'(32'(count) - 32'(k * BLOCK_SIZE)) : '0;
  end

  always_comb begin
    ren      = 1'b0;
    raddr    = '0;
    wen      = 1'b0;
    wr_other = 1'b0;
    waddr    = '0;
    wdata    = val_q;
    case (state)
      S_DECIDE: begin
        if (op_q == OP_APPEND && !full && last_len != FULL_LEN) begin
          wen   = 1'b1;
          waddr = {LAST_BLK, SLOT_W'(last_len)};
        end
      end
      S_LOCATE: begin
        if (found && op_q == OP_QUERY) begin
          ren   = 1'b1;
          raddr = {walk_blk, SLOT_W'(rem)};
        end
      end
      S_SHIFT: begin
        if (rd_active) begin
          ren   = 1'b1;
          raddr = {walk_blk, rd_slot};
        end
        if (pipe_valid) begin
          wen   = 1'b1;
          waddr = {walk_blk, pipe_slot + SLOT_W'(1)};
          wdata = rdata_sel;
        end else if (!rd_active) begin
          // gap is open: drop the new word in
          wen   = 1'b1;
          waddr = {walk_blk, off};
        end
      end
      S_REBUILD: begin
        if (rb_issue) begin
          ren   = 1'b1;
          raddr = {src_blk, SLOT_W'(src_slot)};
        end
        if (pipe_valid) begin
          wen      = 1'b1;
          wr_other = 1'b1;
          waddr    = {dst_blk, dst_slot};
          wdata    = rdata_sel;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      active     <= 1'b0;
      done       <= 1'b0;
      rd_active  <= 1'b0;
      pipe_valid <= 1'b0;
      src_done   <= 1'b0;
      for (int k = 0; k < NUM_BLOCKS; k++) begin
        len[k] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            op_q  <= opcode;
            pos_q <= position;
            val_q <= element_value;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          case (op_q)
            OP_APPEND: begin
              if (full) begin
                done          <= 1'b1;
                read_value    <= '0;
                status        <= ST_FULL;
                element_count <= count;
                state         <= S_IDLE;
              end else if (last_len == FULL_LEN) begin
                src_blk    <= '0;
                src_slot   <= '0;
                src_done   <= 1'b0;
                dst_blk    <= '0;
                dst_slot   <= '0;
                pipe_valid <= 1'b0;
                state      <= S_REBUILD;
              end else begin
                len[LAST_BLK] <= last_len + LEN_W'(1);
                count         <= count + COUNT_W'(1);
                done          <= 1'b1;
                read_value    <= '0;
                status        <= ST_OK;
                element_count <= count + COUNT_W'(1);
                state         <= S_IDLE;
              end
            end
            OP_INSERT, OP_QUERY: begin
              if (pos_bad || (op_q == OP_INSERT && full)) begin
                done          <= 1'b1;
                read_value    <= '0;
                status        <= pos_bad ? ST_RANGE : ST_FULL;
                element_count <= count;
                state         <= S_IDLE;
              end else begin
                walk_blk <= '0;
                rem      <= pos_q - COUNT_W'(1);
                state    <= S_LOCATE;
              end
            end
            default: begin
              done          <= 1'b1;
              read_value    <= '0;
              status        <= ST_RANGE;
              element_count <= count;
              state         <= S_IDLE;
            end
          endcase
        end
        S_LOCATE: begin
          if (found) begin
            if (op_q == OP_QUERY) begin
              state <= S_QWAIT;
            end else if (cur_len == FULL_LEN) begin
              src_blk    <= '0;
              src_slot   <= '0;
              src_done   <= 1'b0;
              dst_blk    <= '0;
              dst_slot   <= '0;
              pipe_valid <= 1'b0;
              state      <= S_REBUILD;
            end else begin
              off        <= SLOT_W'(rem);
              rd_slot    <= SLOT_W'(cur_len - LEN_W'(1));
              rd_active  <= 1'b1;
              pipe_valid <= 1'b0;
              state      <= S_SHIFT;
            end
          end else begin
            rem      <= rem - COUNT_W'(cur_len);
            walk_blk <= walk_blk + BLK_W'(1);
          end
        end
        S_QWAIT: begin
          done          <= 1'b1;
          read_value    <= rdata_sel;
          status        <= ST_OK;
          element_count <= count;
          state         <= S_IDLE;
        end
        S_SHIFT: begin
          // move the block tail up one slot, highest element first
          pipe_valid <= rd_active;
          pipe_slot  <= rd_slot;
          if (rd_active) begin
            if (rd_slot == off) begin
              rd_active <= 1'b0;
            end else begin
              rd_slot <= rd_slot - SLOT_W'(1);
            end
          end
          if (!rd_active && !pipe_valid) begin
            len[walk_blk] <= cur_len + LEN_W'(1);
            count         <= count + COUNT_W'(1);
            done          <= 1'b1;
            read_value    <= '0;
            status        <= ST_OK;
            element_count <= count + COUNT_W'(1);
            state         <= S_IDLE;
          end
        end
        S_REBUILD: begin
          pipe_valid <= rb_issue;
          if (!src_done) begin
            if (rb_issue) begin
              src_slot <= src_slot + LEN_W'(1);
            end else if (src_blk == LAST_BLK) begin
              src_done <= 1'b1;
            end else begin
              src_blk  <= src_blk + BLK_W'(1);
              src_slot <= '0;
            end
          end
          if (pipe_valid) begin
            if (dst_slot == PACK_LAST) begin
              dst_slot <= '0;
              dst_blk  <= dst_blk + BLK_W'(1);
            end else begin
              dst_slot <= dst_slot + SLOT_W'(1);
            end
          end
          if (src_done && !pipe_valid) begin
            // packed copy complete: switch banks and retry the word
            active <= ~active;
            for (int k = 0; k < NUM_BLOCKS; k++) begin
              len[k] <= len_fill[k];
            end
            state <= S_DECIDE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  pistore_bank #(
    .ADDR_W (ADDR_W),
    .DEPTH  (DEPTH)
  ) bank0 (
    .clk   (clk),
    .wen   (wen && !wr_bank),
    .waddr (waddr),
    .wdata (wdata),
    .ren   (ren && !active),
    .raddr (raddr),
    .rdata (rdata0)
  );

  pistore_bank #(
    .ADDR_W (ADDR_W),
    .DEPTH  (DEPTH)
  ) bank1 (
    .clk   (clk),
    .wen   (wen && wr_bank),
    .waddr (waddr),
    .wdata (wdata),
    .ren   (ren && active),
    .raddr (raddr),
    .rdata (rdata1)
  );

endmodule
`default_nettype wire

// ===== rtl/pistore_bank.sv =====
// one synchronous element bank: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module pistore_bank #(
  parameter int ADDR_W = 11,
  parameter int DEPTH  = 2048
) (
  input  wire logic                            clk,
  input  wire logic                            wen,
  input  wire logic [ADDR_W-1:0]               waddr,
  input  wire logic [pistore_pkg::VALUE_W-1:0] wdata,
  input  wire logic                            ren,
  input  wire logic [ADDR_W-1:0]               raddr,
  output logic      [pistore_pkg::VALUE_W-1:0] rdata
);
  import pistore_pkg::*;

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
